// ----- rtl/core/bde_pkg.sv -----
package bde_pkg;

  // Default sizing
  localparam int MAX_ENTRY_LEN_DEF    = 255;
  localparam int BYTES_PER_RESULT_DEF = 4;

  // Fixed dictionary geometry
  localparam int NUM_ENTRIES = 256;
  localparam int MAX_RESULTS = 64;
  localparam int NUM_LANES   = 4;

  // Byte store addressing: entry in the upper byte, position in the lower
  localparam int BYTE_POS_W  = 8;
  localparam int BYTE_ADDR_W = 8 + BYTE_POS_W;

  // Command modes
  localparam logic [1:0] MODE_SET_LEN = 2'd0;
  localparam logic [1:0] MODE_WR_BYTE = 2'd1;
  localparam logic [1:0] MODE_DECODE  = 2'd2;

  // Command transaction payload
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] code;
    logic [7:0] position;
    logic [7:0] value;
  } cmd_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [2:0] byte_count;
    logic       last;
    logic       error;
  } res_t;

  // Dictionary access strobes
  typedef struct packed {
    logic len_we;
    logic len_re;
    logic byte_we;
    logic byte_re;
  } dict_ctl_t;

endpackage

// ----- rtl/core/byte_dictionary_expander.sv -----
// Load transactions (set length, write byte) complete in idle and leave the sequencer ready.
// A decode reads the entry length, then for each result word issues one read per byte on the single
// byte-store read port and presents the word on the output, holding it while res_stall is high.
// An error transaction yields one error word, an empty-entry decode none; one transaction at a time.
// Synchronous active-high reset returns the sequencer to idle and marks all
// entry lengths zero at once through per-entry valid bits; the byte store is not cleared.
module byte_dictionary_expander #(
  parameter int MAX_ENTRY_LEN    = bde_pkg::MAX_ENTRY_LEN_DEF,
  parameter int BYTES_PER_RESULT = bde_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bde_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output bde_pkg::res_t res
);

  bde_pkg::dict_ctl_t              ctl;
  logic [7:0]                      len_addr;
  logic [7:0]                      len_wdata;
  logic [7:0]                      len_rdata;
  logic [bde_pkg::BYTE_ADDR_W-1:0] byte_addr;
  logic [7:0]                      byte_wdata;
  logic [7:0]                      byte_rdata;

  // Sequencer and output register
  bde_seq #(
    .MAX_ENTRY_LEN    (MAX_ENTRY_LEN),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .ctl        (ctl),
    .len_addr   (len_addr),
    .len_wdata  (len_wdata),
    .len_rdata  (len_rdata),
    .byte_addr  (byte_addr),
    .byte_wdata (byte_wdata),
    .byte_rdata (byte_rdata)
  );

  // Dictionary storage
  bde_dict u_dict (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .len_addr   (len_addr),
    .len_wdata  (len_wdata),
    .len_rdata  (len_rdata),
    .byte_addr  (byte_addr),
    .byte_wdata (byte_wdata),
    .byte_rdata (byte_rdata)
  );

endmodule

// ----- rtl/core/bde_dict.sv -----
module bde_dict (
  input  logic                            clk,
  input  logic                            rst,
  input  bde_pkg::dict_ctl_t              ctl,
  input  logic [7:0]                      len_addr,
  input  logic [7:0]                      len_wdata,
  output logic [7:0]                      len_rdata,
  input  logic [bde_pkg::BYTE_ADDR_W-1:0] byte_addr,
  input  logic [7:0]                      byte_wdata,
  output logic [7:0]                      byte_rdata
);

  localparam int BYTE_DEPTH = bde_pkg::NUM_ENTRIES << bde_pkg::BYTE_POS_W;

  logic [7:0]                      len_mem [bde_pkg::NUM_ENTRIES];
  logic [bde_pkg::NUM_ENTRIES-1:0] len_valid;
  logic [7:0]                      len_q;
  logic                            len_vq;
  logic [7:0]                      byte_mem [BYTE_DEPTH];

  // Length valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (ctl.len_we) begin
      len_valid[len_addr] <= 1'b1;
    end
  end

  // Length table, registered read
  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[len_addr] <= len_wdata;
    end
    if (ctl.len_re) begin
      len_q  <= len_mem[len_addr];
      len_vq <= len_valid[len_addr];
    end
  end

  assign len_rdata = len_vq ? len_q : 8'd0;

  // Byte store, registered read
  always_ff @(posedge clk) begin
    if (ctl.byte_we) begin
      byte_mem[byte_addr] <= byte_wdata;
    end
    if (ctl.byte_re) begin
      byte_rdata <= byte_mem[byte_addr];
    end
  end

endmodule

// ----- rtl/core/bde_seq.sv -----
module bde_seq #(
  parameter int MAX_ENTRY_LEN    = bde_pkg::MAX_ENTRY_LEN_DEF,
  parameter int BYTES_PER_RESULT = bde_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  bde_pkg::cmd_t                   cmd,
  output logic                            res_valid,
  input  logic                            res_stall,
  output bde_pkg::res_t                   res,
  output bde_pkg::dict_ctl_t              ctl,
  output logic [7:0]                      len_addr,
  output logic [7:0]                      len_wdata,
  input  logic [7:0]                      len_rdata,
  output logic [bde_pkg::BYTE_ADDR_W-1:0] byte_addr,
  output logic [7:0]                      byte_wdata,
  input  logic [7:0]                      byte_rdata
);

  localparam int PACK_WIDTH = (BYTES_PER_RESULT > bde_pkg::NUM_LANES) ? bde_pkg::NUM_LANES :
                              ((BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LEN_RD = 2'd1;
  localparam logic [1:0] S_FETCH  = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]                    state, state_next;
  logic [7:0]                    code_q, code_q_next;
  logic [bde_pkg::BYTE_POS_W-1:0] pos, pos_next;
  logic [7:0]                    remaining, remaining_next;
  logic [2:0]                    chunk_cnt, chunk_cnt_next;
  logic [2:0]                    issued, issued_next;
  logic [2:0]                    captured, captured_next;
  logic                          rd_pend, rd_pend_next;
  logic [5:0]                    nres, nres_next;
  logic [7:0]                    slot [bde_pkg::NUM_LANES];
  logic [7:0]                    slot_next [bde_pkg::NUM_LANES];
  logic [2:0]                    res_cnt, res_cnt_next;
  logic                          res_last, res_last_next;
  logic                          res_err, res_err_next;

  logic [7:0]       len_sat;
  logic [2:0]       first_chunk;
  logic [2:0]       rem_chunk;
  logic [7:0]       rem_after;
  logic [2:0]       captured_inc;

  // Length saturation and chunk sizing
  assign len_sat      = (cmd.value > 8'(MAX_ENTRY_LEN)) ? 8'(MAX_ENTRY_LEN) : cmd.value;
  assign first_chunk  = (len_rdata < 8'(PACK_WIDTH)) ? len_rdata[2:0] : 3'(PACK_WIDTH);
  assign rem_chunk    = (remaining < 8'(PACK_WIDTH)) ? remaining[2:0] : 3'(PACK_WIDTH);
  assign rem_after    = remaining - {5'd0, chunk_cnt};
  assign captured_inc = captured + 3'd1;

  // Memory addressing
  assign len_addr   = cmd.code;
  assign len_wdata  = len_sat;
  assign byte_wdata = cmd.value;
  assign byte_addr  = (state == S_IDLE) ? {cmd.code, cmd.position[bde_pkg::BYTE_POS_W-1:0]}
                                        : {code_q, pos};

  // Handshake
  assign cmd_stall = (state != S_IDLE);
  assign res_valid = (state == S_OUT);

  assign res.byte_0     = slot[0];
  assign res.byte_1     = slot[1];
  assign res.byte_2     = slot[2];
  assign res.byte_3     = slot[3];
  assign res.byte_count = res_cnt;
  assign res.last       = res_last;
  assign res.error      = res_err;

  // Sequencer
  always_comb begin
    state_next     = state;
    code_q_next    = code_q;
    pos_next       = pos;
    remaining_next = remaining;
    chunk_cnt_next = chunk_cnt;
    issued_next    = issued;
    captured_next  = captured;
    rd_pend_next   = 1'b0;
    nres_next      = nres;
    slot_next      = slot;
    res_cnt_next   = res_cnt;
    res_last_next  = res_last;
    res_err_next   = res_err;
    ctl            = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.mode)
            bde_pkg::MODE_SET_LEN: begin
              if (cmd.value == 8'd0 && cmd.code != 8'd0) begin
                for (int i = 0; i < bde_pkg::NUM_LANES; i++) slot_next[i] = 8'd0;
                res_cnt_next  = 3'd0;
                res_last_next = 1'b1;
                res_err_next  = 1'b1;
                state_next    = S_OUT;
              end else begin
                ctl.len_we = 1'b1;
              end
            end
            bde_pkg::MODE_WR_BYTE: begin
              if (cmd.position < 8'(MAX_ENTRY_LEN)) begin
                ctl.byte_we = 1'b1;
              end
            end
            bde_pkg::MODE_DECODE: begin
              ctl.len_re  = 1'b1;
              code_q_next = cmd.code;
              state_next  = S_LEN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_LEN_RD: begin
        if (len_rdata == 8'd0) begin
          state_next = S_IDLE;
        end else begin
          remaining_next = len_rdata;
          chunk_cnt_next = first_chunk;
          issued_next    = 3'd0;
          captured_next  = 3'd0;
          pos_next       = '0;
          nres_next      = 6'd0;
          for (int i = 0; i < bde_pkg::NUM_LANES; i++) slot_next[i] = 8'd0;
          state_next     = S_FETCH;
        end
      end

      S_FETCH: begin
        // issue one byte read per cycle
        if (issued != chunk_cnt) begin
          ctl.byte_re  = 1'b1;
          pos_next     = pos + 1'b1;
          issued_next  = issued + 3'd1;
          rd_pend_next = 1'b1;
        end
        // capture the byte read last cycle
        if (rd_pend) begin
          slot_next[captured[1:0]] = byte_rdata;
          captured_next = captured_inc;
          if (captured_inc == chunk_cnt) begin
            res_cnt_next   = chunk_cnt;
            res_err_next   = 1'b0;
            res_last_next  = (rem_after == 8'd0) ||
                             (nres == 6'(bde_pkg::MAX_RESULTS - 1));
            remaining_next = rem_after;
            state_next     = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!res_stall) begin
          if (res_last) begin
            state_next = S_IDLE;
          end else begin
            nres_next      = nres + 6'd1;
            chunk_cnt_next = rem_chunk;
            issued_next    = 3'd0;
            captured_next  = 3'd0;
            for (int i = 0; i < bde_pkg::NUM_LANES; i++) slot_next[i] = 8'd0;
            state_next     = S_FETCH;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    code_q    <= code_q_next;
    pos       <= pos_next;
    remaining <= remaining_next;
    chunk_cnt <= chunk_cnt_next;
    issued    <= issued_next;
    captured  <= captured_next;
    nres      <= nres_next;
    slot      <= slot_next;
    res_cnt   <= res_cnt_next;
    res_last  <= res_last_next;
    res_err   <= res_err_next;
  end

  // No new command while a result is pending
  a_stall_on_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cmd_stall)
    else $error("command accepted while result pending");

  // Error result carries no bytes and closes the transaction
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.error) |-> (res.byte_count == 3'd0 && res.last))
    else $error("malformed error result");

  // Data result count within packing width
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.error) |->
      (res.byte_count != 3'd0 && res.byte_count <= 3'(PACK_WIDTH)))
    else $error("bad byte count");

  // Captures never overtake issued reads
  a_capture_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (captured <= issued && issued <= chunk_cnt))
    else $error("fetch counters out of order");

  // Result held until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(res_valid) && $past(res_stall)) |-> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

// ----- test/byte_dictionary_expander_test.sv -----
`timescale 1ns / 100ps

module byte_dictionary_expander_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_LEN = bde_pkg::MAX_ENTRY_LEN_DEF;
  localparam int LANES =
    (bde_pkg::BYTES_PER_RESULT_DEF > bde_pkg::NUM_LANES) ? bde_pkg::NUM_LANES :
    (bde_pkg::BYTES_PER_RESULT_DEF < 1) ? 1 : bde_pkg::BYTES_PER_RESULT_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 28;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  bde_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  bde_pkg::res_t res;

  // Stimulus side
  bde_pkg::cmd_t pending_cmds[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int gen_len [bde_pkg::NUM_ENTRIES];
  bit gen_written [bde_pkg::NUM_ENTRIES][MAX_LEN];
  int loaded_codes[$];
  int gen_items = 0;

  // Dictionary as the block should hold it, updated on accepted transactions
  logic [7:0] dict_len [bde_pkg::NUM_ENTRIES];
  logic [7:0] dict_bytes [bde_pkg::NUM_ENTRIES][MAX_LEN];
  bde_pkg::res_t expected_words[$];

  int cmds_taken = 0;
  int decodes = 0;
  int len_errors = 0;
  int words_checked = 0;
  int failures = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bde_pkg::res_t want_word;

  byte_dictionary_expander i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected result words for one accepted command
  task automatic expand_command(input bde_pkg::cmd_t c);
    bde_pkg::res_t w;
    int len;
    int done;
    int n;
    int cnt;
    logic [7:0] lane [bde_pkg::NUM_LANES];
    cmds_taken++;
    case (c.mode)
      bde_pkg::MODE_SET_LEN: begin
        if (c.value == 8'd0 && c.code != 8'd0) begin
          // zero length on a nonzero entry: error word, length kept
          w = '0;
          w.last = 1'b1;
          w.error = 1'b1;
          expected_words.push_back(w);
          len_errors++;
        end else begin
          dict_len[c.code] = (c.value > MAX_LEN) ? 8'(MAX_LEN) : c.value;
        end
      end
      bde_pkg::MODE_WR_BYTE: begin
        if (c.position < MAX_LEN) dict_bytes[c.code][c.position] = c.value;
      end
      bde_pkg::MODE_DECODE: begin
        decodes++;
        len = (dict_len[c.code] > MAX_LEN) ? MAX_LEN : dict_len[c.code];
        done = 0;
        n = 0;
        while (done < len && n < bde_pkg::MAX_RESULTS) begin
          cnt = (len - done > LANES) ? LANES : len - done;
          for (int j = 0; j < bde_pkg::NUM_LANES; j++) begin
            if (j < cnt) lane[j] = dict_bytes[c.code][done + j];
            else lane[j] = 8'd0;
          end
          done += cnt;
          w.byte_0 = lane[0];
          w.byte_1 = lane[1];
          w.byte_2 = lane[2];
          w.byte_3 = lane[3];
          w.byte_count = 3'(cnt);
          w.last = (done >= len || n == bde_pkg::MAX_RESULTS - 1);
          w.error = 1'b0;
          expected_words.push_back(w);
          n++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int field_bad(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Queue one command and track what the dictionary will hold
  task automatic queue_cmd(input logic [1:0] m, input logic [7:0] c,
                           input logic [7:0] p, input logic [7:0] v);
    bde_pkg::cmd_t t;
    t.mode = m;
    t.code = c;
    t.position = p;
    t.value = v;
    pending_cmds.push_back(t);
    if (m == bde_pkg::MODE_SET_LEN && !(v == 8'd0 && c != 8'd0))
      gen_len[c] = (v > MAX_LEN) ? MAX_LEN : v;
    if (m == bde_pkg::MODE_WR_BYTE && p < MAX_LEN) gen_written[c][p] = 1'b1;
    if (m != MODE_UNUSED) gen_items++;
  endtask

  task automatic queue_decode(input int c);
    queue_cmd(bde_pkg::MODE_DECODE, 8'(c), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // Bytes then length, or length then bytes
  task automatic load_entry(input int c, input int len);
    bit len_first;
    len_first = $urandom_range(1);
    if (len_first)
      queue_cmd(bde_pkg::MODE_SET_LEN, 8'(c), 8'($urandom_range(255)), 8'(len));
    for (int p = 0; p < len; p++)
      queue_cmd(bde_pkg::MODE_WR_BYTE, 8'(c), 8'(p), 8'($urandom_range(255)));
    if (!len_first)
      queue_cmd(bde_pkg::MODE_SET_LEN, 8'(c), 8'($urandom_range(255)), 8'(len));
    loaded_codes.push_back(c);
  endtask

  // A decode must never read a byte that was never written
  function automatic bit decodable(input int c);
    for (int p = 0; p < gen_len[c]; p++)
      if (!gen_written[c][p]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_decode_code();
    int c;
    for (int tries = 0; tries < 8; tries++) begin
      if (loaded_codes.size() != 0 && $urandom_range(3) != 0)
        c = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
      else
        c = $urandom_range(255);
      if (decodable(c)) return c;
    end
    return -1;
  endfunction

  function automatic int pick_loaded();
    if (loaded_codes.size() == 0) return 0;
    return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
  endfunction

  // Mostly well-formed loads and decodes, some errors and noise
  task automatic random_step();
    int r;
    int c;
    int n;
    logic [1:0] m;
    r = $urandom_range(99);
    if (r < 25) begin
      c = $urandom_range(255);
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      load_entry(c, n);
      if ($urandom_range(3) == 0) queue_decode(c);
    end else if (r < 68) begin
      c = pick_decode_code();
      if (c >= 0) queue_decode(c);
    end else if (r < 76) begin
      queue_cmd(bde_pkg::MODE_SET_LEN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'd0);
    end else if (r < 84) begin
      c = pick_loaded();
      if (gen_len[c] > 0)
        queue_cmd(bde_pkg::MODE_WR_BYTE, 8'(c), 8'($urandom_range(gen_len[c] - 1)),
                  8'($urandom_range(255)));
    end else if (r < 90) begin
      c = pick_loaded();
      if (gen_len[c] > 1 && decodable(c))
        queue_cmd(bde_pkg::MODE_SET_LEN, 8'(c), 8'($urandom_range(255)),
                  8'($urandom_range(1, gen_len[c])));
    end else if (r < 94) begin
      queue_cmd(MODE_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end else begin
      // random command of a valid mode; decodes only of decodable entries
      m = 2'($urandom_range(2));
      c = $urandom_range(255);
      if (m != bde_pkg::MODE_DECODE || decodable(c))
        queue_cmd(m, 8'(c), 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  // Command driver; predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) expand_command(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold counted here
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", res);
        failures++;
      end else begin
        want_word = expected_words.pop_front();
        words_checked++;
        failures += field_bad("byte_0", want_word.byte_0, res.byte_0)
                  + field_bad("byte_1", want_word.byte_1, res.byte_1)
                  + field_bad("byte_2", want_word.byte_2, res.byte_2)
                  + field_bad("byte_3", want_word.byte_3, res.byte_3)
                  + field_bad("byte_count", 8'(want_word.byte_count), 8'(res.byte_count))
                  + field_bad("last", 8'(want_word.last), 8'(res.last))
                  + field_bad("error", 8'(want_word.error), 8'(res.error));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    int start;
    idle_plan = '{0, 50, 0, 25};
    stall_plan = '{0, 0, 50, 25};
    for (int e = 0; e < bde_pkg::NUM_ENTRIES; e++) begin
      dict_len[e] = 8'd0;
      gen_len[e] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty entries, length errors, packing edges, ignored writes
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd0, 8'd0, 8'd0);
    queue_decode(0);
    queue_decode(255);
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd1, 8'hFF, 8'd0);
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'hFF, 8'd0, 8'd0);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd2, 8'd0, 8'hFF);
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd2, 8'd0, 8'd1);
    queue_decode(2);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd3, 8'd0, 8'h00);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd3, 8'd1, 8'hFF);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd3, 8'd2, 8'hA5);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd3, 8'd3, 8'h5A);
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd3, 8'h00, 8'd4);
    queue_decode(3);
    queue_cmd(bde_pkg::MODE_WR_BYTE, 8'd3, 8'hFF, 8'h77);  // past the end, ignored
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd3, 8'd0, 8'd0);    // error, length stays 4
    queue_decode(3);
    load_entry(4, 5);
    queue_decode(4);
    queue_cmd(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    load_entry(0, 3);
    queue_decode(0);
    queue_cmd(bde_pkg::MODE_SET_LEN, 8'd0, 8'd0, 8'd0);
    queue_decode(0);
    // full-length entry: 64 words, last one marked
    load_entry(255, MAX_LEN);
    queue_decode(255);
    wait_drained();

    // Back-pressure: long receiver hold while decodes keep coming
    for (int k = 0; k < 10; k++) queue_decode((k % 3 == 0) ? 255 : 3 + (k % 2));
    hold_asked = hold_asked + 1;
    wait_drained();

    // Random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      start = gen_items;
      while (gen_items - start < PHASE_ITEMS) random_step();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d commands: %0d decodes, %0d zero-length errors, %0d words checked",
             cmds_taken, decodes, len_errors, words_checked);
    $display("Idle patterns: none, sender, receiver, both; plus one %0d-cycle receiver hold",
             HOLD_CYCLES);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bde_pkg.sv
rtl/core/bde_dict.sv
rtl/core/bde_seq.sv
rtl/core/byte_dictionary_expander.sv
test/byte_dictionary_expander_test.sv
